[design/websocket_frame_deframer_defines.svh]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_defines.svh
// Assertion macros shared by the deframer checkers.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define WSFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define WSFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/wsfd_pkg.sv]
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants of the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  // Result kinds (m_axis_tuser)
  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_ERR_127  = 2'd2;
  localparam logic [1:0] KIND_ERR_LONG = 2'd3;

  // Reset value of the maximum payload length register
  localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

  // Width of the packed result tdata (46 field bits, padded to bytes)
  localparam int unsigned RES_DATA_W = 48;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic        final_fragment;
    logic        was_masked;
    logic [15:0] payload_length;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic        last;
  } res_t;

endpackage

[design/wsfd_parser.sv]
// ----------------------------------------------------------------------------
// wsfd_parser
// Header phase tracking, length check, key capture and payload unmasking.
// One accepted byte updates the state and yields at most one result.
// ----------------------------------------------------------------------------
module wsfd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_fire,
  input  logic [7:0]         rx_byte,
  output logic               res_valid,
  output wsfd_pkg::res_t     res
);

  // Parse phases
  localparam logic [3:0] PH_HDR0  = 4'd0;
  localparam logic [3:0] PH_HDR1  = 4'd1;
  localparam logic [3:0] PH_EXTHI = 4'd2;
  localparam logic [3:0] PH_EXTLO = 4'd3;
  localparam logic [3:0] PH_KEY0  = 4'd4;
  localparam logic [3:0] PH_KEY1  = 4'd5;
  localparam logic [3:0] PH_KEY2  = 4'd6;
  localparam logic [3:0] PH_KEY3  = 4'd7;
  localparam logic [3:0] PH_DATA  = 4'd8;

  localparam logic [6:0] CODE_EXT16 = 7'd126;
  localparam logic [6:0] CODE_EXT64 = 7'd127;

  logic [15:0] max_len;
  logic [3:0]  phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        final_bit, final_bit_next;
  logic        masked, masked_next;
  logic [15:0] frame_len, frame_len_next;
  logic [15:0] count, count_next;
  logic [31:0] key, key_next;

  logic [15:0] len_cand;
  logic        len_done;
  logic        too_long;
  logic [16:0] count_inc;
  logic        data_last;
  logic [7:0]  key_byte;

  // Config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= wsfd_pkg::MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  // Decoded length: 7-bit code or completed extended length
  assign len_cand  = (phase == PH_EXTLO) ? {frame_len[15:8], rx_byte}
                                         : {9'd0, rx_byte[6:0]};
  assign too_long  = len_cand > max_len;
  assign count_inc = {1'b0, count} + 17'd1;
  assign data_last = count_inc >= {1'b0, frame_len};
  assign key_byte  = key[{count[1:0], 3'b000} +: 8];

  // Next state and result
  always_comb begin
    phase_next     = phase;
    opcode_next    = opcode;
    final_bit_next = final_bit;
    masked_next    = masked;
    frame_len_next = frame_len;
    count_next     = count;
    key_next       = key;
    len_done       = 1'b0;
    res_valid      = 1'b0;
    res.kind           = wsfd_pkg::KIND_START;
    res.payload_length = 16'd0;
    res.byte_index     = 16'd0;
    res.data_byte      = 8'd0;
    res.last           = 1'b0;

    case (phase)
      PH_HDR1: begin
        masked_next = rx_byte[7];
        if (!rx_byte[7]) begin
          key_next = 32'd0;
        end
        if (rx_byte[6:0] == CODE_EXT64) begin
          phase_next = PH_HDR0;
          res_valid  = 1'b1;
          res.kind   = wsfd_pkg::KIND_ERR_127;
          res.last   = 1'b1;
        end else if (rx_byte[6:0] == CODE_EXT16) begin
          phase_next = PH_EXTHI;
        end else begin
          len_done = 1'b1;
        end
      end
      PH_EXTHI: begin
        frame_len_next = {rx_byte, 8'd0};
        phase_next     = PH_EXTLO;
      end
      PH_EXTLO: begin
        len_done = 1'b1;
      end
      PH_KEY0, PH_KEY1, PH_KEY2, PH_KEY3: begin
        key_next[{phase[1:0], 3'b000} +: 8] = rx_byte;
        if (phase != PH_KEY3) begin
          phase_next = phase + 4'd1;
        end else begin
          count_next         = 16'd0;
          phase_next         = (frame_len == 16'd0) ? PH_HDR0 : PH_DATA;
          res_valid          = 1'b1;
          res.kind           = wsfd_pkg::KIND_START;
          res.payload_length = frame_len;
          res.last           = frame_len == 16'd0;
        end
      end
      PH_DATA: begin
        count_next         = count_inc[15:0];
        if (data_last) begin
          phase_next = PH_HDR0;
        end
        res_valid          = 1'b1;
        res.kind           = wsfd_pkg::KIND_PAYLOAD;
        res.payload_length = frame_len;
        res.byte_index     = count;
        res.data_byte      = masked ? (rx_byte ^ key_byte) : rx_byte;
        res.last           = data_last;
      end
      default: begin
        opcode_next    = rx_byte[3:0];
        final_bit_next = rx_byte[7];
        phase_next     = PH_HDR1;
      end
    endcase

    // Length known: range check, then key, payload or next header
    if (len_done) begin
      frame_len_next = len_cand;
      if (too_long) begin
        phase_next         = PH_HDR0;
        res_valid          = 1'b1;
        res.kind           = wsfd_pkg::KIND_ERR_LONG;
        res.payload_length = len_cand;
        res.last           = 1'b1;
      end else if (masked_next) begin
        phase_next = PH_KEY0;
      end else begin
        count_next         = 16'd0;
        phase_next         = (len_cand == 16'd0) ? PH_HDR0 : PH_DATA;
        res_valid          = 1'b1;
        res.kind           = wsfd_pkg::KIND_START;
        res.payload_length = len_cand;
        res.last           = len_cand == 16'd0;
      end
    end

    res.opcode         = opcode;
    res.final_fragment = final_bit;
    res.was_masked     = masked_next;
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR0;
      opcode    <= 4'd0;
      final_bit <= 1'b0;
      masked    <= 1'b0;
      frame_len <= 16'd0;
      count     <= 16'd0;
      key       <= 32'd0;
    end else if (in_fire) begin
      phase     <= phase_next;
      opcode    <= opcode_next;
      final_bit <= final_bit_next;
      masked    <= masked_next;
      frame_len <= frame_len_next;
      count     <= count_next;
      key       <= key_next;
    end
  end

endmodule

[design/wsfd_out_reg.sv]
// ----------------------------------------------------------------------------
// wsfd_out_reg
// Result register toward the master stream; packs the result fields.
// ----------------------------------------------------------------------------
module wsfd_out_reg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  wsfd_pkg::res_t                    res,
  output logic                              free,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wsfd_pkg::RES_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic [1:0]                        m_axis_tuser
);

  wsfd_pkg::res_t held;

  // Slot can take a new request when empty or being drained this cycle
  assign free = !m_axis_tvalid || m_axis_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (free) begin
      m_axis_tvalid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {2'b00, held.data_byte, held.byte_index, held.payload_length,
                         held.was_masked, held.final_fragment, held.opcode};
  assign m_axis_tlast = held.last;
  assign m_axis_tuser = held.kind;

endmodule

[design/websocket_frame_deframer.sv]
// A result appears on m_axis in the cycle after the byte that causes it.
// Throughput: one byte per cycle; s_axis_tready is high while the result
//   register is empty or being drained (a single output register sets this).
// Reset (rst, synchronous): parser waits for a first header byte, frame state
//   and masking key clear, max_payload_length returns to 1024, no result held.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side WebSocket frame parser with payload unmasking.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [15:0]                      cfg_wr_data,   // max_payload_length
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // opcode[3:0], final_fragment[4], was_masked[5], payload_length[21:6],
  // byte_index[37:22], data_byte[45:38], zero pad[47:46]
  output logic [wsfd_pkg::RES_DATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,  // last
  output logic [1:0]                       m_axis_tuser   // kind
);

  logic           in_fire;
  logic           res_valid;
  logic           out_free;
  wsfd_pkg::res_t res;

  assign s_axis_tready = out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  wsfd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_fire     (in_fire),
    .rx_byte     (s_axis_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsfd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (in_fire && res_valid),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[design/wsfd_checker.sv]
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_frame_deframer_defines.svh"

module wsfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [wsfd_pkg::RES_DATA_W-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast,
  input logic [1:0]                       m_axis_tuser
);

  // A stalled result holds its data
  `WSFD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  // Input is never blocked while no result is pending
  `WSFD_ASSERT_NOW(a_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // Errors always close the frame
  `WSFD_ASSERT_NOW(a_err_last, m_axis_tvalid && (m_axis_tuser == wsfd_pkg::KIND_ERR_127 || m_axis_tuser == wsfd_pkg::KIND_ERR_LONG), m_axis_tlast, "error without last")

  // Non-payload results carry zero index and data
  `WSFD_ASSERT_NOW(a_hdr_zero, m_axis_tvalid && m_axis_tuser != wsfd_pkg::KIND_PAYLOAD, m_axis_tdata[45:22] == 24'd0, "index or data set on non-payload result")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/sv/websocket_frame_deframer_checker.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches the byte stream into the deframer and the results out of it,
// parses the stream with its own copy of the header/key/payload state, and
// compares each result with the oldest one predicted. It reports the failure
// count, the number of results still due and whether the parser is waiting
// for a first header byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [15:0]                      cfg_wr_data,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [wsfd_pkg::RES_DATA_W-1:0]  m_axis_tdata,
  input  logic                             m_axis_tlast,
  input  logic [1:0]                       m_axis_tuser,
  output int                               fail_count,
  output int                               pending,
  output logic                             hdr_wait
);
  timeunit 1ns;
  timeprecision 1ps;
  import wsfd_pkg::*;

  // 7-bit length codes that announce an extended length
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam int         MAX_SHOWN   = 10;

  typedef enum logic [3:0] {
    ST_HDR0, ST_HDR1, ST_EXT_HI, ST_EXT_LO,
    ST_KEY0, ST_KEY1, ST_KEY2, ST_KEY3, ST_DATA
  } parse_state_e;

  // Shadow parser state
  parse_state_e state       = ST_HDR0;
  logic [15:0]  max_len     = MAX_LEN_RESET;
  logic [3:0]   frame_op    = '0;
  logic         frame_fin   = 1'b0;
  logic         frame_msk   = 1'b0;
  logic [15:0]  frame_len   = '0;
  logic [15:0]  payload_idx = '0;
  logic [31:0]  key         = '0;

  res_t results_due[$];
  int   errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    hdr_wait   = 1'b1;
  end

  function automatic res_t make_result(input logic [1:0] kind, input logic [15:0] plen,
                                       input logic [15:0] idx, input logic [7:0] data,
                                       input logic last);
    res_t r;
    r.kind           = kind;
    r.opcode         = frame_op;
    r.final_fragment = frame_fin;
    r.was_masked     = frame_msk;
    r.payload_length = plen;
    r.byte_index     = idx;
    r.data_byte      = data;
    r.last           = last;
    return r;
  endfunction

  // Header done: frame-start result, empty frames end right here
  function automatic bit start_payload(output res_t r);
    payload_idx = '0;
    state = (frame_len == 0) ? ST_HDR0 : ST_DATA;
    r = make_result(KIND_START, frame_len, '0, '0, frame_len == 0);
    return 1'b1;
  endfunction

  // Length decoded: limit check, then key bytes or payload
  function automatic bit length_known(output res_t r);
    r = '0;
    if (frame_len > max_len) begin
      state = ST_HDR0;
      r = make_result(KIND_ERR_LONG, frame_len, '0, '0, 1'b1);
      return 1'b1;
    end
    if (frame_msk) begin
      state = ST_KEY0;
      return 1'b0;
    end
    return start_payload(r);
  endfunction

  // Advance the shadow parser by one byte; returns 1 when a result is due
  function automatic bit parse_byte(input logic [7:0] b, output res_t r);
    logic [7:0]  key_byte;
    logic [16:0] next_idx;
    int          slot;
    r = '0;
    case (state)
      ST_HDR1: begin
        frame_msk = b[7];
        if (!b[7]) key = '0;
        if (b[6:0] == LEN_CODE_64) begin
          state = ST_HDR0;
          r = make_result(KIND_ERR_127, '0, '0, '0, 1'b1);
          return 1'b1;
        end
        if (b[6:0] == LEN_CODE_16) begin
          state = ST_EXT_HI;
          return 1'b0;
        end
        frame_len = {9'd0, b[6:0]};
        return length_known(r);
      end
      ST_EXT_HI: begin
        frame_len = {b, 8'h00};
        state = ST_EXT_LO;
        return 1'b0;
      end
      ST_EXT_LO: begin
        frame_len[7:0] = b;
        return length_known(r);
      end
      ST_KEY0, ST_KEY1, ST_KEY2, ST_KEY3: begin
        slot = int'(state) - int'(ST_KEY0);
        key[8*slot +: 8] = b;
        if (state != ST_KEY3) begin
          state = parse_state_e'(state + 1);
          return 1'b0;
        end
        return start_payload(r);
      end
      ST_DATA: begin
        // key byte picked by index mod 4
        key_byte = key[8*payload_idx[1:0] +: 8];
        next_idx = {1'b0, payload_idx} + 17'd1;
        r = make_result(KIND_PAYLOAD, frame_len, payload_idx,
                        frame_msk ? (b ^ key_byte) : b, next_idx >= {1'b0, frame_len});
        payload_idx = next_idx[15:0];
        if (r.last) state = ST_HDR0;
        return 1'b1;
      end
      default: begin
        frame_op  = b[3:0];
        frame_fin = b[7];
        state     = ST_HDR1;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string show(input res_t r);
    return $sformatf("kind=%0d op=%h fin=%b msk=%b len=%0d idx=%0d data=%h last=%b",
                     r.kind, r.opcode, r.final_fragment, r.was_masked, r.payload_length,
                     r.byte_index, r.data_byte, r.last);
  endfunction

  // Compare accepted results, then predict from the accepted request
  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    res_t predicted;
    if (rst) begin
      state       = ST_HDR0;
      max_len     = MAX_LEN_RESET;
      frame_op    = '0;
      frame_fin   = 1'b0;
      frame_msk   = 1'b0;
      frame_len   = '0;
      payload_idx = '0;
      key         = '0;
      results_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind           = m_axis_tuser;
        got.opcode         = m_axis_tdata[3:0];
        got.final_fragment = m_axis_tdata[4];
        got.was_masked     = m_axis_tdata[5];
        got.payload_length = m_axis_tdata[21:6];
        got.byte_index     = m_axis_tdata[37:22];
        got.data_byte      = m_axis_tdata[45:38];
        got.last           = m_axis_tlast;
        if (results_due.size() == 0) begin
          if (errors < MAX_SHOWN)
            $display("%0t unexpected result: %s", $realtime, show(got));
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got !== want || m_axis_tdata[RES_DATA_W-1:46] !== '0) begin
            if (errors < MAX_SHOWN) begin
              $display("%0t result mismatch (pad=%b)", $realtime,
                       m_axis_tdata[RES_DATA_W-1:46]);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            errors++;
          end
        end
      end
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        if (parse_byte(s_axis_tdata, predicted)) results_due.push_back(predicted);
      end
    end
    pending    <= results_due.size();
    hdr_wait   <= (state == ST_HDR0);
    fail_count <= errors;
  end

endmodule

[tb/sv/websocket_frame_deframer_tb.sv]
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Drives WebSocket frames into the deframer: a directed set of header and
// length corner cases under several payload limits, a frame right at a small
// limit, then random frames, error headers and junk bytes with random gaps on
// the input and random stalls on the output. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wsfd_pkg::*;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam int         MAX_LEN_7   = 125;
  localparam int         MAX_LEN_16  = 65535;
  localparam int         EDGE_LIMIT  = 40;
  // Longest correct quiet stretch is a long stall plus a drain, well under this limit
  localparam int         QUIET_LIMIT = 2000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [15:0]             cfg_wr_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [RES_DATA_W-1:0]   m_axis_tdata;
  logic                    m_axis_tlast;
  logic [1:0]              m_axis_tuser;

  int   fail_count;
  int   pending;
  logic hdr_wait;

  bit   idle_on    = 1'b1;
  int   stall_left = 0;
  int   quiet      = 0;
  int   items      = 0;
  int   cur_max    = int'(MAX_LEN_RESET);

  websocket_frame_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  websocket_frame_deframer_checker chk (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending       (pending),
    .hdr_wait      (hdr_wait)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Output side: random stalls, mostly short
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      m_axis_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) :
                                                  $urandom_range(8, 40);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("websocket_frame_deframer regression: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // One request: optional gap, then hold until accepted
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items++;
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_max(input int v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[15:0];
    cur_max = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Whole frame; stops after the length when it exceeds the limit
  task automatic send_frame(input logic [3:0] op, input bit fin, input bit msk,
                            input int len, input bit ext);
    logic [31:0] mask_key;
    mask_key = $urandom;
    send_byte({fin, 3'($urandom_range(0, 7)), op});
    if (ext || len > MAX_LEN_7) begin
      send_byte({msk, LEN_CODE_16});
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte({msk, 7'(len)});
    end
    if (len > cur_max) return;
    if (msk) for (int i = 0; i < 4; i++) send_byte(mask_key[8*i +: 8]);
    for (int i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  task automatic send_code64(input logic [3:0] op, input bit msk);
    send_byte({1'($urandom), 3'($urandom_range(0, 7)), op});
    send_byte({msk, LEN_CODE_64});
  endtask

  // Junk bytes, then feed one byte at a time until a header is expected again
  task automatic send_junk();
    repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (!hdr_wait) begin
      send_byte(8'($urandom));
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_frames(input int n_items);
    int stop;
    int r;
    int q;
    int len;
    stop = items + n_items;
    while (items < stop) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_code64(4'($urandom), 1'($urandom));
      end else if (r < 13 && cur_max < MAX_LEN_16) begin
        len = cur_max + 1 + $urandom_range(0, 40);
        if (len > MAX_LEN_16) len = MAX_LEN_16;
        send_frame(4'($urandom), 1'($urandom), 1'($urandom), len, 1'($urandom));
      end else if (r < 18 && cur_max <= 1024) begin
        send_junk();
      end else begin
        q = $urandom_range(0, 99);
        if (q < 80) len = $urandom_range(0, 8);
        else if (q < 95) len = $urandom_range(9, 60);
        else len = $urandom_range(126, 160);
        if (len > cur_max) len = cur_max;
        send_frame(4'($urandom), 1'($urandom), 1'($urandom), len,
                   $urandom_range(0, 4) == 0);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset limit: empty frames, key wrap, length edges, both error kinds
    send_frame(4'h0, 1'b0, 1'b0, 0, 1'b0);
    send_frame(4'hF, 1'b1, 1'b1, 0, 1'b0);
    send_frame(4'h1, 1'b1, 1'b0, 1, 1'b0);
    send_frame(4'h2, 1'b1, 1'b1, 5, 1'b0);
    send_frame(4'h8, 1'b1, 1'b1, MAX_LEN_7, 1'b0);
    send_frame(4'h9, 1'b0, 1'b0, 3, 1'b1);
    send_frame(4'hA, 1'b1, 1'b1, 0, 1'b1);
    send_frame(4'h1, 1'b1, 1'b1, MAX_LEN_7 + 5, 1'b1);
    send_frame(4'h2, 1'b0, 1'b1, int'(MAX_LEN_RESET) + 1, 1'b1);
    send_code64(4'h5, 1'b1);
    send_code64(4'h6, 1'b0);
    send_frame(4'h3, 1'b1, 1'b0, 4, 1'b0);

    // Zero limit: only empty payloads pass
    set_max(0);
    send_frame(4'h1, 1'b1, 1'b1, 0, 1'b0);
    send_frame(4'h1, 1'b1, 1'b0, 1, 1'b0);
    send_frame(4'h2, 1'b0, 1'b1, MAX_LEN_16, 1'b1);

    // Small limit: a frame right at the limit, then one byte over, back to back
    set_max(EDGE_LIMIT);
    idle_on <= 1'b0;
    send_frame(4'h2, 1'b1, 1'b1, EDGE_LIMIT, 1'b1);
    send_frame(4'h2, 1'b1, 1'b0, EDGE_LIMIT + 1, 1'b1);
    drain();
    idle_on <= 1'b1;

    // Random traffic under a range of limits
    set_max(int'(MAX_LEN_RESET));
    random_frames(80);
    set_max($urandom_range(8, 200));
    idle_on <= 1'b0;
    random_frames(60);
    idle_on <= 1'b1;
    set_max(MAX_LEN_16);
    random_frames(60);
    set_max(0);
    random_frames(60);
    set_max($urandom_range(126, 2000));
    random_frames(60);

    drain();
    if (fail_count == 0) begin
      $display("websocket_frame_deframer regression: pass");
    end else begin
      $display("websocket_frame_deframer regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/wsfd_pkg.sv
design/wsfd_parser.sv
design/wsfd_out_reg.sv
design/websocket_frame_deframer.sv
design/wsfd_checker.sv
tb/sv/websocket_frame_deframer_checker.sv
tb/sv/websocket_frame_deframer_tb.sv
